// File: rtl/core/mced_pkg.sv
// Shared types and constants for the multi-channel debounce block.
// Used by the interfaces, the configuration registers, the channel cells and the top level.
package mced_pkg;

    // Payload widths fixed by the pin bus
    localparam int unsigned BUS_W   = 8;
    localparam int unsigned INDEX_W = 3;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 4;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_DEBOUNCE_TICKS = 2'd0,
        REG_INVERT_MASK    = 2'd1,
        REG_RISING_MASK    = 2'd2,
        REG_FALLING_MASK   = 2'd3
    } mced_reg_t;

    // Register reset values
    localparam logic [TICKS_W-1:0] DEBOUNCE_TICKS_RST = 16'd50;

    // Configuration set handed to the datapath
    typedef struct packed {
        logic [TICKS_W-1:0] debounce_ticks;
        logic [BUS_W-1:0]   invert_mask;
        logic [BUS_W-1:0]   rising_mask;
        logic [BUS_W-1:0]   falling_mask;
    } mced_cfg_t;

    // Priority chain passed from each cell to the next higher channel
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic               value;
    } mced_chain_t;

    // Per-channel status of one tick
    typedef struct packed {
        logic level;
        logic rise;
        logic fall;
    } mced_cell_out_t;

endpackage

// File: rtl/core/mced_if.sv
// Valid/ready channel interfaces for pin-bus samples and event words.
// Depends on mced_pkg for the payload widths.
interface mced_in_if
    import mced_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [BUS_W-1:0] raw_levels;

    modport source (output valid, output raw_levels, input ready);
    modport sink   (input valid, input raw_levels, output ready);
endinterface

interface mced_out_if
    import mced_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BUS_W-1:0]   levels;
    logic [BUS_W-1:0]   rising_flags;
    logic [BUS_W-1:0]   falling_flags;
    logic               wake;
    logic [INDEX_W-1:0] first_index;
    logic               first_value;

    modport source (output valid, output levels, output rising_flags, output falling_flags,
                    output wake, output first_index, output first_value, input ready);
    modport sink   (input valid, input levels, input rising_flags, input falling_flags,
                    input wake, input first_index, input first_value, output ready);
endinterface

// File: rtl/core/mced_cfg.sv
// APB-style configuration registers of the debounce block.
// Depends on mced_pkg for the register map and the configuration struct.
module mced_cfg
    import mced_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output mced_cfg_t         cfg
);
    mced_cfg_t cfg_reg;
    mced_cfg_t cfg_next;
    mced_reg_t sel;
    logic      wr_en;

    assign pready = 1'b1;
    assign sel    = mced_reg_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                REG_DEBOUNCE_TICKS: cfg_next.debounce_ticks = pwdata[TICKS_W-1:0];
                REG_INVERT_MASK:    cfg_next.invert_mask    = pwdata[BUS_W-1:0];
                REG_RISING_MASK:    cfg_next.rising_mask    = pwdata[BUS_W-1:0];
                REG_FALLING_MASK:   cfg_next.falling_mask   = pwdata[BUS_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= DEBOUNCE_TICKS_RST;
            cfg_reg.invert_mask    <= '0;
            cfg_reg.rising_mask    <= '0;
            cfg_reg.falling_mask   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register on reads
    always_comb
    begin
        case (sel)
            REG_DEBOUNCE_TICKS: prdata = {{(DATA_W-TICKS_W){1'b0}}, cfg_reg.debounce_ticks};
            REG_INVERT_MASK:    prdata = {{(DATA_W-BUS_W){1'b0}}, cfg_reg.invert_mask};
            REG_RISING_MASK:    prdata = {{(DATA_W-BUS_W){1'b0}}, cfg_reg.rising_mask};
            REG_FALLING_MASK:   prdata = {{(DATA_W-BUS_W){1'b0}}, cfg_reg.falling_mask};
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;
endmodule

// File: rtl/core/mced_cell.sv
// One debounce channel: quiet timer, previous raw level and debounced level.
// Passes the lowest-match priority chain on to the next channel. Depends on mced_pkg.
module mced_cell
    import mced_pkg::*;
#(
    parameter int unsigned INDEX        = 0,
    parameter int unsigned COUNTER_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    primed,
    input  logic                    raw,
    input  logic                    invert,
    input  logic                    rise_en,
    input  logic                    fall_en,
    input  logic [COUNTER_BITS-1:0] load,
    input  mced_chain_t             chain_in,
    output mced_chain_t             chain_out,
    output mced_cell_out_t          status
);
    logic [COUNTER_BITS-1:0] count_reg;
    logic [COUNTER_BITS-1:0] count_next;
    logic                    prev_reg;
    logic                    stable_reg;
    logic                    stable_next;
    logic [COUNTER_BITS-1:0] count_dec;
    logic                    sample;
    logic                    rise;
    logic                    fall;
    logic                    match;

    assign sample    = raw ^ invert;
    assign count_dec = count_reg - COUNTER_BITS'(1);

    // Unprimed, copy the sample; else reload on a raw edge, count down, sample at zero
    always_comb
    begin
        count_next  = count_reg;
        stable_next = stable_reg;
        rise        = 1'b0;
        fall        = 1'b0;
        if (!primed)
        begin
            stable_next = sample;
        end
        else if (raw != prev_reg)
        begin
            count_next = load;
        end
        else if (count_reg != '0)
        begin
            count_next = count_dec;
            if (count_dec == '0)
            begin
                stable_next = sample;
                rise        = sample && !stable_reg;
                fall        = !sample && stable_reg;
            end
        end
    end

    // Advance the channel state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            prev_reg   <= 1'b0;
            stable_reg <= 1'b0;
        end
        else if (advance)
        begin
            count_reg  <= count_next;
            prev_reg   <= raw;
            stable_reg <= stable_next;
        end
    end

    // Claim the chain if no lower channel matched
    assign match = (rise && rise_en) || (fall && fall_en);

    always_comb
    begin
        chain_out = chain_in;
        if (!chain_in.found && match)
        begin
            chain_out.found = 1'b1;
            chain_out.index = INDEX_W'(INDEX);
            chain_out.value = stable_next;
        end
    end

    assign status.level = stable_next;
    assign status.rise  = rise;
    assign status.fall  = fall;
endmodule

// File: rtl/core/multi_channel_debounce_edge_events.sv
// Multi-channel switch debouncer with debounced edge events.
// The event word of an accepted sample word is loaded into the output register in the cycle after it is accepted.
// Throughput: one word per cycle; the cells update in parallel, and a new word enters
// as the previous event word leaves; input stalls only while an event word waits unread.
// Reset (rst_n, asynchronous, active low): timers idle, levels zero, block unprimed,
// configuration registers at their reset values; the event word registers are not reset. No clearing pass.
module multi_channel_debounce_edge_events
    import mced_pkg::*;
#(
    parameter int unsigned CHANNELS     = 8,
    parameter int unsigned COUNTER_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    mced_in_if.sink           sample_in,
    mced_out_if.source        event_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);
    localparam logic [32:0] CNT_MAX_W = (33'd1 << COUNTER_BITS) - 33'd1;
    localparam logic [31:0] CNT_MAX   = CNT_MAX_W[31:0];

    mced_cfg_t               cfg;
    logic                    accept;
    logic                    primed_reg;
    logic                    out_valid_reg;
    logic [31:0]             ticks_ext;
    logic [31:0]             load_ext;
    logic [COUNTER_BITS-1:0] load;
    mced_chain_t             chain [CHANNELS+1];
    mced_cell_out_t          cell_st [CHANNELS];
    logic [BUS_W-1:0]        levels_next;
    logic [BUS_W-1:0]        rise_next;
    logic [BUS_W-1:0]        fall_next;

    logic [BUS_W-1:0]        levels_reg;
    logic [BUS_W-1:0]        rise_reg;
    logic [BUS_W-1:0]        fall_reg;
    logic                    wake_reg;
    logic [INDEX_W-1:0]      index_reg;
    logic                    value_reg;

    mced_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Take a word whenever the output register is free or being emptied
    assign sample_in.ready = !out_valid_reg || event_out.ready;
    assign accept          = sample_in.valid && sample_in.ready;

    // Clamp the reload value: zero counts as one, saturate at the counter range
    assign ticks_ext = {{(32-TICKS_W){1'b0}}, cfg.debounce_ticks};
    always_comb
    begin
        if (ticks_ext == 32'd0)
            load_ext = 32'd1;
        else if (ticks_ext > CNT_MAX)
            load_ext = CNT_MAX;
        else
            load_ext = ticks_ext;
    end
    assign load = load_ext[COUNTER_BITS-1:0];

    // Row of channel cells, priority chain from channel 0 upwards
    assign chain[0] = '0;

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_cell
        mced_cell #(
            .INDEX        (i),
            .COUNTER_BITS (COUNTER_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (accept),
            .primed    (primed_reg),
            .raw       (sample_in.raw_levels[i]),
            .invert    (cfg.invert_mask[i]),
            .rise_en   (cfg.rising_mask[i]),
            .fall_en   (cfg.falling_mask[i]),
            .load      (load),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .status    (cell_st[i])
        );
    end

    // Gather the cell status into bus words; unused channels read zero
    always_comb
    begin
        levels_next = '0;
        rise_next   = '0;
        fall_next   = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            levels_next[i] = cell_st[i].level;
            rise_next[i]   = cell_st[i].rise;
            fall_next[i]   = cell_st[i].fall;
        end
    end

    // Mark the block primed after the first word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            primed_reg <= 1'b0;
        else if (accept)
            primed_reg <= 1'b1;
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (event_out.ready)
            out_valid_reg <= 1'b0;
    end

    // Load the event word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            levels_reg <= levels_next;
            rise_reg   <= rise_next;
            fall_reg   <= fall_next;
            wake_reg   <= chain[CHANNELS].found;
            index_reg  <= chain[CHANNELS].index;
            value_reg  <= chain[CHANNELS].value;
        end
    end

    assign event_out.valid         = out_valid_reg;
    assign event_out.levels        = levels_reg;
    assign event_out.rising_flags  = rise_reg;
    assign event_out.falling_flags = fall_reg;
    assign event_out.wake          = wake_reg;
    assign event_out.first_index   = index_reg;
    assign event_out.first_value   = value_reg;

`ifndef ASSERT_OFF
    // A channel never rises and falls in the same tick
    a_no_double_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((rise_reg & fall_reg) == '0))
        else $error("channel flagged both rising and falling");

    // Input stalls only while a finished word waits
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_in.ready |-> (out_valid_reg && !event_out.ready))
        else $error("input stalled with free output register");

    // The reported channel carries an edge and its new level
    a_first_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && wake_reg) |->
            (((rise_reg | fall_reg) >> index_reg) & 8'd1) == 8'd1
            && levels_reg[index_reg] == value_reg)
        else $error("first_index does not name a flagged channel");

    // The priming word raises no flags
    a_prime_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !primed_reg) |=> (rise_reg == '0 && fall_reg == '0 && !wake_reg))
        else $error("flags raised on the priming word");
`endif
endmodule
